// ----- src/tld_pkg.sv -----
// ----------------------------------------------------------------------------
// tld_pkg
// Types, codes and the output conversion shared by the line discipline.
// ----------------------------------------------------------------------------
package tld_pkg;

  localparam logic [1:0] OP_RX = 2'd0;
  localparam logic [1:0] OP_TX = 2'd1;
  localparam logic [1:0] OP_RD = 2'd2;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOERASE = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_NOREAD  = 3'd3;
  localparam logic [2:0] ST_IGNORED = 3'd4;

  localparam logic [2:0] REG_IMODE  = 3'd0;
  localparam logic [2:0] REG_OMODE  = 3'd1;
  localparam logic [2:0] REG_LMODE  = 3'd2;
  localparam logic [2:0] REG_ERASE  = 3'd3;
  localparam logic [2:0] REG_KILL   = 3'd4;
  localparam logic [2:0] REG_LEND   = 3'd5;
  localparam logic [2:0] REG_START  = 3'd6;
  localparam logic [2:0] REG_STOP   = 3'd7;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CASE_OFS = 8'd32;

  localparam logic [7:0] RST_ERASE = 8'd8;
  localparam logic [7:0] RST_KILL  = 8'd11;
  localparam logic [7:0] RST_START = 8'd17;
  localparam logic [7:0] RST_STOP  = 8'd19;

  typedef struct packed {
    logic [6:0]  imode;
    logic [3:0]  omode;
    logic [4:0]  lmode;
    logic [7:0]  erase_char;
    logic [7:0]  kill_char;
    logic [15:0] line_end;
    logic [7:0]  start_char;
    logic [7:0]  stop_char;
  } cfg_t;

  typedef struct packed {
    logic [1:0] cnt;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } tx_t;

  typedef struct packed {
    tx_t        tx;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       read_line_end;
    logic       stopped;
    logic [2:0] status;
    logic       last;
  } res_t;

  function automatic tx_t out_conv(input logic [7:0] c, input logic [3:0] om);
    tx_t        t;
    logic [7:0] u;
    t = '0;
    u = c;
    if (!om[0]) begin
      t.cnt = 2'd1;
      t.b0  = c;
    end else begin
      if (om[1] && c >= "a" && c <= "z") u = c - CASE_OFS;
      if (om[2] && u == CH_NL) begin
        t.cnt = 2'd2;
        t.b0  = CH_CR;
        t.b1  = CH_NL;
      end else begin
        t.cnt = 2'd1;
        t.b0  = (om[3] && u == CH_CR) ? CH_NL : u;
      end
    end
    return t;
  endfunction

endpackage

// ----- src/terminal_line_discipline_unit.sv -----
// ----------------------------------------------------------------------------
// terminal_line_discipline_unit
// Terminal line discipline with input ring, echo and output conversion.
// ----------------------------------------------------------------------------
// Usage: items enter on s_axis (tuser = op, tdata = ch); each item yields one
// or more result beats on m_axis, the final one marked by tlast. Registers
// are to be written over the APB port only while no item is in flight; the
// block itself does not enforce this. One item at a time: a new item can be
// taken in the cycle after the final beat of the previous one has been loaded
// into the output register. A kill walks the ring back one removed character
// at a time through the states S_KL_DEC and S_KL_CHK; a canonical read scans
// the ring one entry per cycle through the single memory read port.
// Reset clears head, tail, stopped flag and registers; the ring contents are
// not cleared and need no clearing pass.
// When the receiver stalls, the sequencer holds in place with at most one
// beat in the output register and one queued behind it.
// ----------------------------------------------------------------------------
module terminal_line_discipline_unit #(
  parameter int RING_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // ch
  input  logic [1:0]  s_axis_tuser,   // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tx_count, tx_first, tx_second, tx_third, read_valid, read_byte,
  // read_line_end, output_stopped, zero fill
  output logic [39:0] m_axis_tdata,
  output logic [2:0]  m_axis_tuser,   // status
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(RING_DEPTH);

  tld_pkg::cfg_t cfg;
  tld_pkg::res_t res;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, mem_rdata;
  logic [2:0]    reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.imode      <= '0;
      cfg.omode      <= '0;
      cfg.lmode      <= '0;
      cfg.erase_char <= tld_pkg::RST_ERASE;
      cfg.kill_char  <= tld_pkg::RST_KILL;
      cfg.line_end   <= '0;
      cfg.start_char <= tld_pkg::RST_START;
      cfg.stop_char  <= tld_pkg::RST_STOP;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        tld_pkg::REG_IMODE: cfg.imode      <= pwdata[6:0];
        tld_pkg::REG_OMODE: cfg.omode      <= pwdata[3:0];
        tld_pkg::REG_LMODE: cfg.lmode      <= pwdata[4:0];
        tld_pkg::REG_ERASE: cfg.erase_char <= pwdata[7:0];
        tld_pkg::REG_KILL:  cfg.kill_char  <= pwdata[7:0];
        tld_pkg::REG_LEND:  cfg.line_end   <= pwdata[15:0];
        tld_pkg::REG_START: cfg.start_char <= pwdata[7:0];
        tld_pkg::REG_STOP:  cfg.stop_char  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      tld_pkg::REG_IMODE: prdata = {25'd0, cfg.imode};
      tld_pkg::REG_OMODE: prdata = {28'd0, cfg.omode};
      tld_pkg::REG_LMODE: prdata = {27'd0, cfg.lmode};
      tld_pkg::REG_ERASE: prdata = {24'd0, cfg.erase_char};
      tld_pkg::REG_KILL:  prdata = {24'd0, cfg.kill_char};
      tld_pkg::REG_LEND:  prdata = {16'd0, cfg.line_end};
      tld_pkg::REG_START: prdata = {24'd0, cfg.start_char};
      tld_pkg::REG_STOP:  prdata = {24'd0, cfg.stop_char};
      default:            prdata = '0;
    endcase
  end

  tld_ring #(.RING_DEPTH(RING_DEPTH)) u_ring (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  tld_ctrl #(.RING_DEPTH(RING_DEPTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .s_valid   (s_axis_tvalid),
    .s_ready   (s_axis_tready),
    .s_op      (s_axis_tuser),
    .s_ch      (s_axis_tdata),
    .m_valid   (m_axis_tvalid),
    .m_ready   (m_axis_tready),
    .m_res     (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  assign m_axis_tdata = {3'd0, res.stopped, res.read_line_end, res.read_byte,
                         res.read_valid, res.tx.b2, res.tx.b1, res.tx.b0, res.tx.cnt};
  assign m_axis_tuser = res.status;
  assign m_axis_tlast = res.last;

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second item taken while busy");

  a_read_single: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[26] |-> m_axis_tlast && m_axis_tdata[1:0] == 2'd0)
    else $error("read beat with transmit bytes");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tuser <= tld_pkg::ST_IGNORED)
    else $error("bad status code");

endmodule

// ----- src/tld_ring.sv -----
// ----------------------------------------------------------------------------
// tld_ring
// Input character ring: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tld_ring #(
  parameter int RING_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [$clog2(RING_DEPTH)-1:0] waddr,
  input  logic [7:0]                    wdata,
  input  logic [$clog2(RING_DEPTH)-1:0] raddr,
  output logic [7:0]                    rdata
);

  logic [7:0] mem [RING_DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ----- src/tld_ctrl.sv -----
// ----------------------------------------------------------------------------
// tld_ctrl
// Sequencer: input mapping, erase/kill walk, line search, echo and results.
// ----------------------------------------------------------------------------
module tld_ctrl #(
  parameter int RING_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  tld_pkg::cfg_t                 cfg,
  input  logic                          s_valid,
  output logic                          s_ready,
  input  logic [1:0]                    s_op,
  input  logic [7:0]                    s_ch,
  output logic                          m_valid,
  input  logic                          m_ready,
  output tld_pkg::res_t                 m_res,
  output logic                          mem_we,
  output logic [$clog2(RING_DEPTH)-1:0] mem_waddr,
  output logic [7:0]                    mem_wdata,
  output logic [$clog2(RING_DEPTH)-1:0] mem_raddr,
  input  logic [7:0]                    mem_rdata
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(RING_DEPTH - 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DEC    = 4'd1;
  localparam logic [3:0] S_ECHO   = 4'd2;
  localparam logic [3:0] S_STORE  = 4'd3;
  localparam logic [3:0] S_ER_CHK = 4'd4;
  localparam logic [3:0] S_KL_DEC = 4'd5;
  localparam logic [3:0] S_KL_CHK = 4'd6;
  localparam logic [3:0] S_KL_END = 4'd7;
  localparam logic [3:0] S_RD_T   = 4'd8;
  localparam logic [3:0] S_SC     = 4'd9;
  localparam logic [3:0] S_POP    = 4'd10;
  localparam logic [3:0] S_FIN    = 4'd11;

  function automatic logic [AW-1:0] nxt(input logic [AW-1:0] i);
    return (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [AW-1:0] prv(input logic [AW-1:0] i);
    return (i == '0) ? LAST_IDX : i - 1'b1;
  endfunction

  function automatic logic is_term(input logic [7:0] b, input logic [15:0] le);
    return b == le[7:0] || b == le[15:8] || b == tld_pkg::CH_NL;
  endfunction

  logic [3:0]    state;
  logic [1:0]    op;
  logic [7:0]    c;
  logic          ign;
  logic          is_kill;
  logic          full;
  logic [2:0]    status;
  logic          stopped;
  logic [AW-1:0] head;
  logic [AW-1:0] tail;
  logic [AW-1:0] scan_i;
  logic [7:0]    tbyte;
  logic          rd_valid;
  logic [7:0]    rd_byte;
  logic          rd_end;
  logic          hv;
  tld_pkg::tx_t  hold;

  logic [7:0]    s1, s2, mc;
  logic          out_free, emit_req, emit_ok, adv, load;
  tld_pkg::tx_t  emit_tx;

  // receive mapping
  always_comb begin
    s1 = cfg.imode[0] ? {1'b0, s_ch[6:0]} : s_ch;
    if (cfg.imode[2] && s1 == tld_pkg::CH_NL)      s2 = tld_pkg::CH_CR;
    else if (cfg.imode[3] && s1 == tld_pkg::CH_CR) s2 = tld_pkg::CH_NL;
    else                                           s2 = s1;
    mc = (cfg.imode[4] && s2 >= "A" && s2 <= "Z") ? s2 + tld_pkg::CASE_OFS : s2;
  end

  always_comb begin
    emit_req = 1'b0;
    emit_tx  = '0;
    unique case (state)
      S_ECHO: begin
        emit_req = 1'b1;
        emit_tx  = tld_pkg::out_conv(c, cfg.omode);
      end
      S_KL_DEC: begin
        emit_req = cfg.lmode[2] && cfg.lmode[1];
        emit_tx  = '{cnt: 2'd3, b0: tld_pkg::CH_BS, b1: tld_pkg::CH_SPACE,
                     b2: tld_pkg::CH_BS};
      end
      S_KL_END: begin
        emit_req = cfg.lmode[3];
        emit_tx  = tld_pkg::out_conv(tld_pkg::CH_NL, cfg.omode);
      end
      default: ;
    endcase
  end

  always_comb begin
    unique case (state)
      S_DEC:    mem_raddr = (op == tld_pkg::OP_RD) ? tail : prv(head);
      S_KL_DEC: mem_raddr = prv(prv(head));
      S_RD_T:   mem_raddr = nxt(tail);
      S_SC:     mem_raddr = nxt(scan_i);
      default:  mem_raddr = tail;
    endcase
  end

  assign out_free  = !m_valid || m_ready;
  assign emit_ok   = !hv || out_free;
  assign adv       = !emit_req || emit_ok;
  assign load      = (emit_req && emit_ok && hv) || (state == S_FIN && out_free);
  assign s_ready   = (state == S_IDLE);
  assign mem_we    = (state == S_STORE) && !full;
  assign mem_waddr = head;
  assign mem_wdata = c;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      head    <= '0;
      tail    <= '0;
      stopped <= 1'b0;
      hv      <= 1'b0;
      m_valid <= 1'b0;
    end else begin
      if (load) begin
        m_valid             <= 1'b1;
        m_res.tx            <= (state == S_FIN && !hv) ? '0 : hold;
        m_res.read_valid    <= rd_valid;
        m_res.read_byte     <= rd_byte;
        m_res.read_line_end <= rd_end;
        m_res.stopped       <= stopped;
        m_res.status        <= status;
        m_res.last          <= (state == S_FIN);
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
      if (emit_req && emit_ok) begin
        hold <= emit_tx;
        hv   <= 1'b1;
      end

      unique case (state)
        S_IDLE: begin
          if (s_valid) begin
            op       <= s_op;
            c        <= (s_op == tld_pkg::OP_RX) ? mc : s_ch;
            ign      <= cfg.imode[1] && s1 == tld_pkg::CH_CR;
            status   <= tld_pkg::ST_OK;
            rd_valid <= 1'b0;
            rd_byte  <= '0;
            rd_end   <= 1'b0;
            state    <= S_DEC;
          end
        end
        S_DEC: begin
          full <= (nxt(head) == tail);
          unique case (op)
            tld_pkg::OP_RX: begin
              if (ign) begin
                status <= tld_pkg::ST_IGNORED;
                state  <= S_FIN;
              end else if (cfg.lmode[0] && (c == cfg.erase_char || c == cfg.kill_char)) begin
                is_kill <= (c == cfg.kill_char);
                if (head == tail) begin
                  status <= tld_pkg::ST_NOERASE;
                  state  <= S_FIN;
                end else begin
                  state <= S_ER_CHK;
                end
              end else if (cfg.imode[6] && (c == cfg.stop_char || c == cfg.start_char)) begin
                stopped <= (c == cfg.stop_char) && (c != cfg.start_char);
                state   <= S_FIN;
              end else begin
                if (cfg.imode[5]) stopped <= 1'b0;
                status <= (nxt(head) == tail) ? tld_pkg::ST_FULL : tld_pkg::ST_OK;
                state  <= (cfg.lmode[1] || (cfg.lmode[4] && c == tld_pkg::CH_NL)) ?
                          S_ECHO : S_STORE;
              end
            end
            tld_pkg::OP_TX: state <= S_ECHO;
            tld_pkg::OP_RD: begin
              if (head == tail) begin
                status <= tld_pkg::ST_NOREAD;
                state  <= S_FIN;
              end else begin
                state <= S_RD_T;
              end
            end
            default: begin
              status <= tld_pkg::ST_IGNORED;
              state  <= S_FIN;
            end
          endcase
        end
        S_ECHO: begin
          if (adv) state <= (op == tld_pkg::OP_TX) ? S_FIN : S_STORE;
        end
        S_STORE: begin
          if (!full) head <= nxt(head);
          state <= S_FIN;
        end
        S_ER_CHK: begin
          if (is_term(mem_rdata, cfg.line_end)) begin
            status <= tld_pkg::ST_NOERASE;
            state  <= S_FIN;
          end else begin
            state <= S_KL_DEC;
          end
        end
        S_KL_DEC: begin
          if (adv) begin
            head <= prv(head);
            if (!is_kill)               state <= S_FIN;
            else if (prv(head) == tail) state <= S_KL_END;
            else                        state <= S_KL_CHK;
          end
        end
        S_KL_CHK: begin
          state <= is_term(mem_rdata, cfg.line_end) ? S_KL_END : S_KL_DEC;
        end
        S_KL_END: begin
          if (adv) state <= S_FIN;
        end
        S_RD_T: begin
          tbyte  <= mem_rdata;
          scan_i <= nxt(tail);
          if (!cfg.lmode[0] || is_term(mem_rdata, cfg.line_end)) begin
            state <= S_POP;
          end else if (nxt(tail) == head) begin
            status <= tld_pkg::ST_NOREAD;
            state  <= S_FIN;
          end else begin
            state <= S_SC;
          end
        end
        S_SC: begin
          if (is_term(mem_rdata, cfg.line_end)) begin
            state <= S_POP;
          end else if (nxt(scan_i) == head) begin
            status <= tld_pkg::ST_NOREAD;
            state  <= S_FIN;
          end else begin
            scan_i <= nxt(scan_i);
          end
        end
        S_POP: begin
          rd_valid <= 1'b1;
          rd_byte  <= tbyte;
          rd_end   <= is_term(tbyte, cfg.line_end);
          tail     <= nxt(tail);
          state    <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            hv    <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
